// ----- src/rau_pkg.sv -----
`timescale 1ns / 1ps
package rau_pkg;
   localparam int WIDTH = 32;
   localparam int MW = 64;
   localparam int SUMW = 65;
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;
   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_ZERO = 2'd1,
      ST_OVF = 2'd2
   } status_type;
   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_SUM,
      S_GCD_INIT,
      S_MOD,
      S_MOD_STEP,
      S_DIVN_INIT,
      S_DIVN,
      S_DIVD_INIT,
      S_DIVD,
      S_CLAMP,
      S_OUT
   } state_type;
   typedef struct packed {
      logic [1:0] opcode;
      logic signed [31:0] a_numerator;
      logic signed [31:0] a_denominator;
      logic signed [31:0] b_numerator;
      logic signed [31:0] b_denominator;
   } req_type;
   typedef struct packed {
      logic signed [31:0] result_numerator;
      logic [30:0] result_denominator;
      logic [1:0] status;
   } rsp_type;
endpackage

// ----- src/rau_if.sv -----
`timescale 1ns / 1ps
interface rau_req_if;
   import rau_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rau_rsp_if;
   import rau_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- src/rational_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// channel   role    handshake      payload
// req       sink    valid/ready    opcode, a/b numerator, a/b denominator
// rsp       source  valid/ready    result numerator, denominator, status
// One request at a time; req ready only in idle.
// Steps: products (S_MUL1, S_MUL2 for add/sub, S_MUL3), setup (S_SUM,
// S_GCD_INIT), gcd modulo steps (S_MOD zero test, then one-bit S_MOD_STEP
// subtracts), then S_DIVN_INIT and two restoring divisions on the shared
// subtractor. A zero denominator, or divide by zero, skips to the result.
// Reset is synchronous; rsp holds until taken, then the unit returns to idle.
module rational_arithmetic_unit (
   input logic clock,
   input logic reset,
   rau_req_if.sink req,
   rau_rsp_if.source rsp
);
   import rau_pkg::*;

   localparam logic [SUMW-1:0] LIM = SUMW'((65'd1 << (WIDTH - 1)) - 65'd1);

   state_type state_ff, state_in;
   req_type req_ff;
   logic [31:0] x_mag, y_mag;
   logic [63:0] prod;
   logic [63:0] p1_ff, p1_in;
   logic [63:0] p2_ff, p2_in;
   logic [63:0] den_ff, den_in;
   logic an_s, ad_s, bn_s, bd_s;
   logic [31:0] anm, adm, bnm, bdm;
   logic [SUMW-1:0] num_ff, num_in;
   logic nneg_ff, nneg_in;
   logic [SUMW-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [SUMW-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [SUMW-1:0] rn_ff, rn_in;
   logic [SUMW-1:0] diff;
   logic [SUMW:0] trial;
   logic [SUMW-1:0] divisor, dividend;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic bad;
   logic neg_r;
   logic [SUMW-1:0] rd_c, rn_c;
   logic ovf;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (~v + 32'd1) : v;
   endfunction

   assign an_s = req_ff.a_numerator[31];
   assign ad_s = req_ff.a_denominator[31];
   assign bn_s = req_ff.b_numerator[31];
   assign bd_s = req_ff.b_denominator[31];
   assign anm = mag32(req_ff.a_numerator);
   assign adm = mag32(req_ff.a_denominator);
   assign bnm = mag32(req_ff.b_numerator);
   assign bdm = mag32(req_ff.b_denominator);
   assign bad = (adm == '0) || (bdm == '0) ||
                ((req_ff.opcode == OP_DIV) && (bnm == '0));

   // shared multiplier operand select
   always_comb begin
      x_mag = anm;
      y_mag = bdm;
      case (state_ff)
         S_MUL1: begin
            x_mag = anm;
            y_mag = (req_ff.opcode == OP_MUL) ? bnm : bdm;
         end
         S_MUL2: begin
            x_mag = bnm;
            y_mag = adm;
         end
         S_MUL3: begin
            x_mag = adm;
            y_mag = (req_ff.opcode == OP_DIV) ? bnm : bdm;
         end
         default: begin
            x_mag = anm;
            y_mag = bdm;
         end
      endcase
   end
   assign prod = {32'd0, x_mag} * {32'd0, y_mag};

   // shared divider datapath
   always_comb begin
      divisor = gy_ff;
      dividend = gx_ff;
      case (state_ff)
         S_DIVN: dividend = num_ff;
         S_DIVD: dividend = {1'b0, den_ff};
         default: dividend = gx_ff;
      endcase
   end
   assign trial = {rem_ff, dividend[7'(SUMW - 1) - cnt_ff]} - {1'b0, divisor};
   assign diff = trial[SUMW-1:0];

   always_comb begin
      logic s1, s2;
      s1 = 1'b0;
      s2 = 1'b0;
      state_in = state_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      den_in = den_ff;
      num_in = num_ff;
      nneg_in = nneg_ff;
      gx_in = gx_ff;
      gy_in = gy_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      rn_in = rn_ff;
      case (state_ff)
         S_IDLE: if (req.valid) state_in = S_MUL1;
         S_MUL1: begin
            if (bad) begin
               state_in = S_CLAMP;
            end else begin
               p1_in = prod;
               state_in = (req_ff.opcode == OP_MUL || req_ff.opcode == OP_DIV)
                  ? S_MUL3 : S_MUL2;
            end
         end
         S_MUL2: begin
            p2_in = prod;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            den_in = prod;
            state_in = (req_ff.opcode == OP_MUL || req_ff.opcode == OP_DIV)
               ? S_SUM : S_SUM;
         end
         S_SUM: begin
            case (req_ff.opcode)
               OP_ADD: begin
                  s1 = an_s ^ bd_s;
                  s2 = bn_s ^ ad_s;
               end
               OP_SUB: begin
                  s1 = an_s ^ bd_s;
                  s2 = ~(bn_s ^ ad_s);
               end
               OP_MUL: s1 = an_s ^ bn_s;
               default: s1 = an_s ^ bd_s;
            endcase
            if (req_ff.opcode == OP_MUL || req_ff.opcode == OP_DIV) begin
               num_in = {1'b0, p1_ff};
               nneg_in = s1;
            end else if (s1 == s2) begin
               num_in = {1'b0, p1_ff} + {1'b0, p2_ff};
               nneg_in = s1;
            end else if (p1_ff >= p2_ff) begin
               num_in = {1'b0, p1_ff - p2_ff};
               nneg_in = s1;
            end else begin
               num_in = {1'b0, p2_ff - p1_ff};
               nneg_in = s2;
            end
            case (req_ff.opcode)
               OP_DIV: nneg_in = nneg_in ^ ad_s ^ bn_s;
               default: nneg_in = nneg_in ^ ad_s ^ bd_s;
            endcase
            state_in = S_GCD_INIT;
         end
         S_GCD_INIT: begin
            gx_in = num_ff;
            gy_in = {1'b0, den_ff};
            state_in = S_MOD;
         end
         S_MOD: begin
            if (gy_ff == '0) begin
               state_in = S_DIVN_INIT;
            end else begin
               rem_in = '0;
               cnt_in = '0;
               state_in = S_MOD_STEP;
            end
         end
         S_MOD_STEP: begin
            rem_in = trial[SUMW] ? {rem_ff[SUMW-2:0], gx_ff[7'(SUMW - 1) - cnt_ff]}
                                 : diff;
            if (cnt_ff == 7'(SUMW - 1)) begin
               gx_in = gy_ff;
               gy_in = rem_in;
               state_in = S_MOD;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         S_DIVN_INIT: begin
            gy_in = gx_ff;
            rem_in = '0;
            quo_in = '0;
            cnt_in = '0;
            state_in = S_DIVN;
         end
         S_DIVN, S_DIVD: begin
            rem_in = trial[SUMW] ? {rem_ff[SUMW-2:0], dividend[7'(SUMW - 1) - cnt_ff]}
                                 : diff;
            quo_in = {quo_ff[SUMW-2:0], ~trial[SUMW]};
            if (cnt_ff == 7'(SUMW - 1)) begin
               if (state_ff == S_DIVN) begin
                  rn_in = quo_in;
                  rem_in = '0;
                  quo_in = '0;
                  cnt_in = '0;
                  state_in = S_DIVD;
               end else begin
                  state_in = S_CLAMP;
               end
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         S_CLAMP: state_in = S_OUT;
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // result formatting
   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      neg_r = (rn_ff != '0) && nneg_ff;
      rd_c = quo_ff;
      rn_c = rn_ff;
      ovf = 1'b0;
      if (rd_c > LIM) begin
         rd_c = LIM;
         ovf = 1'b1;
      end
      if (neg_r) begin
         if (rn_c > LIM + SUMW'(1)) begin
            rn_c = LIM + SUMW'(1);
            ovf = 1'b1;
         end
         rn_c = ~rn_c + SUMW'(1);
      end else if (rn_c > LIM) begin
         rn_c = LIM;
         ovf = 1'b1;
      end
      if (state_ff == S_CLAMP) begin
         rsp_valid_in = 1'b1;
         if (bad) begin
            rsp_in.result_numerator = '0;
            rsp_in.result_denominator = '0;
            rsp_in.status = ST_ZERO;
         end else begin
            rsp_in.result_numerator = rn_c[31:0];
            rsp_in.result_denominator = rd_c[30:0];
            rsp_in.status = ovf ? ST_OVF : ST_OK;
         end
      end else if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (state_ff == S_IDLE && req.valid) req_ff <= req.data;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      den_ff <= den_in;
      num_ff <= num_in;
      nneg_ff <= nneg_in;
      gx_ff <= gx_in;
      gy_ff <= gy_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      rn_ff <= rn_in;
      rsp_ff <= rsp_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;
endmodule

// ----- src/rau_checker.sv -----
`timescale 1ns / 1ps
module rau_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   a_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after accept");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data)) else $error("rsp changed");
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_ZERO |-> rsp_data.result_denominator == '0)
      else $error("error with denominator");
   a_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_ZERO |-> rsp_data.result_denominator != '0)
      else $error("zero denominator");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_data(rsp.data)
);

// ----- test/tb_rational_arithmetic_unit.sv -----
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
   import rau_pkg::*;

   localparam int RANDOM_REQUESTS = 1930;
   localparam int CYCLE_LIMIT = 40_000_000;

   typedef struct {
      req_type req;
      bit typed;
      rsp_type rsp;
   } vector_type;

   logic clock;
   logic reset;
   int cycle_count;
   int errors;
   rsp_type pending_results[$];
   vector_type vectors[$];

   rau_req_if req_ch();
   rau_rsp_if rsp_ch();

   rational_arithmetic_unit dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic rsp_type fraction_result(req_type r);
      logic [64:0] lim;
      logic an_neg, ad_neg, bn_neg, bd_neg;
      logic [64:0] an, ad, bn, bd;
      logic [64:0] p_mag, q_mag, num_mag, den_mag, x, y, t, rn, rd;
      logic p_neg, q_neg, num_neg, den_neg, neg;
      rsp_type o;
      lim = (65'd1 << (WIDTH - 1)) - 65'd1;
      an_neg = r.a_numerator[31];
      ad_neg = r.a_denominator[31];
      bn_neg = r.b_numerator[31];
      bd_neg = r.b_denominator[31];
      an = {33'd0, an_neg ? 32'(-r.a_numerator) : 32'(r.a_numerator)};
      ad = {33'd0, ad_neg ? 32'(-r.a_denominator) : 32'(r.a_denominator)};
      bn = {33'd0, bn_neg ? 32'(-r.b_numerator) : 32'(r.b_numerator)};
      bd = {33'd0, bd_neg ? 32'(-r.b_denominator) : 32'(r.b_denominator)};
      o.status = ST_OK;
      if (ad == 0 || bd == 0 || (op_type'(r.opcode) == OP_DIV && bn == 0)) begin
         o.result_numerator = '0;
         o.result_denominator = '0;
         o.status = ST_ZERO;
         return o;
      end
      case (op_type'(r.opcode))
         OP_ADD, OP_SUB: begin
            p_mag = an * bd;
            p_neg = (p_mag != 0) && (an_neg != bd_neg);
            q_mag = bn * ad;
            q_neg = (q_mag != 0) && (bn_neg != ad_neg);
            if (op_type'(r.opcode) == OP_SUB) q_neg = (q_mag != 0) && !q_neg;
            if (p_neg == q_neg) begin
               num_mag = p_mag + q_mag;
               num_neg = p_neg;
            end else if (p_mag >= q_mag) begin
               num_mag = p_mag - q_mag;
               num_neg = p_neg;
            end else begin
               num_mag = q_mag - p_mag;
               num_neg = q_neg;
            end
            if (num_mag == 0) num_neg = 1'b0;
            den_mag = ad * bd;
            den_neg = ad_neg != bd_neg;
         end
         OP_MUL: begin
            num_mag = an * bn;
            num_neg = (num_mag != 0) && (an_neg != bn_neg);
            den_mag = ad * bd;
            den_neg = ad_neg != bd_neg;
         end
         default: begin
            num_mag = an * bd;
            num_neg = (num_mag != 0) && (an_neg != bd_neg);
            den_mag = ad * bn;
            den_neg = ad_neg != bn_neg;
         end
      endcase
      x = num_mag;
      y = den_mag;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      rn = num_mag / x;
      rd = den_mag / x;
      neg = (rn != 0) && (num_neg != den_neg);
      if (rd > lim) begin
         rd = lim;
         o.status = ST_OVF;
      end
      if (neg) begin
         if (rn > lim + 1) begin
            rn = lim + 1;
            o.status = ST_OVF;
         end
         o.result_numerator = 32'(-rn);
      end else begin
         if (rn > lim) begin
            rn = lim;
            o.status = ST_OVF;
         end
         o.result_numerator = 32'(rn);
      end
      o.result_denominator = 31'(rd);
      return o;
   endfunction

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 11))
         0: return 32'd0;
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         3: return 32'hffff_ffff;
         4, 5, 6: return 32'($signed($urandom_range(0, 40)) - 20);
         7: return 32'($signed($urandom_range(0, 2000)) - 1000);
         8: return $urandom() >> $urandom_range(0, 31);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] random_denominator();
      logic [31:0] v;
      v = random_operand();
      if (v == 0 && $urandom_range(0, 7) != 0) v = 32'd1;
      return v;
   endfunction

   function automatic vector_type vec(op_type op, int an, int ad, int bn, int bd,
                                      bit typed = 0, int rn = 0, int rd = 0,
                                      status_type st = ST_OK);
      vector_type v;
      v.req.opcode = op;
      v.req.a_numerator = an;
      v.req.a_denominator = ad;
      v.req.b_numerator = bn;
      v.req.b_denominator = bd;
      v.typed = typed;
      v.rsp.result_numerator = rn;
      v.rsp.result_denominator = 31'(rd);
      v.rsp.status = st;
      return v;
   endfunction

   task automatic send_request(req_type r, rsp_type expected, int gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(expected);
      @(negedge clock);
   endtask

   function automatic int draw_gap();
      return (cycle_count % 40000 < 8000) ? 0 : $urandom_range(0, 17);
   endfunction

   initial begin
      int mn, mx;
      vector_type v;
      req_type r;
      mn = 32'h8000_0000;
      mx = 32'h7fff_ffff;
      errors = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      vectors.push_back(vec(OP_ADD, 1, 0, 1, 1, 1, 0, 0, ST_ZERO));
      vectors.push_back(vec(OP_MUL, 3, 2, 5, 0, 1, 0, 0, ST_ZERO));
      vectors.push_back(vec(OP_DIV, 3, 2, 0, 7, 1, 0, 0, ST_ZERO));
      vectors.push_back(vec(OP_SUB, 0, 0, 0, 0, 1, 0, 0, ST_ZERO));
      vectors.push_back(vec(OP_SUB, 5, 3, 5, 3, 1, 0, 1, ST_OK));
      vectors.push_back(vec(OP_MUL, 0, 9, 7, -4, 1, 0, 1, ST_OK));
      vectors.push_back(vec(OP_ADD, 1, 2, 1, 3, 1, 5, 6, ST_OK));
      vectors.push_back(vec(OP_DIV, 1, -2, 3, 4, 1, -2, 3, ST_OK));
      vectors.push_back(vec(OP_MUL, mn, 1, mn, 1, 1, mx, 1, ST_OVF));
      vectors.push_back(vec(OP_MUL, mn, 1, mx, 1, 1, mn, 1, ST_OVF));
      vectors.push_back(vec(OP_MUL, 1, mn, 1, mn, 1, 1, mx, ST_OVF));
      vectors.push_back(vec(OP_ADD, mx, 1, mx, 1, 1, mx, 1, ST_OVF));
      vectors.push_back(vec(OP_SUB, mn, 1, 0, 1, 1, mn, 1, ST_OK));
      vectors.push_back(vec(OP_DIV, mn, 1, -1, 1));
      vectors.push_back(vec(OP_ADD, mn, mn, mx, mx));
      vectors.push_back(vec(OP_SUB, mx, mn, mn, mx));
      vectors.push_back(vec(OP_DIV, mx, mn, mx, mn));
      vectors.push_back(vec(OP_MUL, -1, -1, -1, -1));
      vectors.push_back(vec(OP_ADD, 7, -3, -7, 3));
      vectors.push_back(vec(OP_DIV, 1, mx, mn, 1));
      vectors.push_back(vec(OP_SUB, 1, mx, 1, mx - 1));
      vectors.push_back(vec(OP_MUL, 65536, 3, 65536, 5));

      foreach (vectors[i]) begin
         v = vectors[i];
         send_request(v.req, v.typed ? v.rsp : fraction_result(v.req), draw_gap());
      end
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         r.opcode = 2'($urandom_range(0, 3));
         r.a_numerator = random_operand();
         r.a_denominator = random_denominator();
         r.b_numerator = random_operand();
         r.b_denominator = random_denominator();
         send_request(r, fraction_result(r), draw_gap());
      end
      req_ch.valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("tb_rational_arithmetic_unit: done, clean");
      end else begin
         $display("tb_rational_arithmetic_unit: done, errors");
      end
      $finish;
   end

   initial begin
      int gap;
      rsp_type want;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (pending_results.size() == 0) begin
            $error("unexpected result: numerator %0d", $signed(rsp_ch.data.result_numerator));
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.data.result_numerator !== want.result_numerator) begin
               $error("result_numerator: expected %0d, actual %0d",
                      $signed(want.result_numerator), $signed(rsp_ch.data.result_numerator));
               errors++;
            end
            if (rsp_ch.data.result_denominator !== want.result_denominator) begin
               $error("result_denominator: expected %0d, actual %0d",
                      want.result_denominator, rsp_ch.data.result_denominator);
               errors++;
            end
            if (rsp_ch.data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_ch.data.status);
               errors++;
            end
         end
         @(negedge clock);
      end
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_rational_arithmetic_unit: done, errors");
         $finish;
      end
   end
endmodule

// ----- rational_arithmetic_unit.f -----
src/rau_pkg.sv
src/rau_if.sv
src/rational_arithmetic_unit.sv
src/rau_checker.sv
test/tb_rational_arithmetic_unit.sv
